// ===== hw/rtl/mcdb_pkg.sv =====
// Types, codes and register field helpers shared by the debounce block.
package mcdb_pkg;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_EVENT   = 2'd1,
        PH_WAIT    = 2'd2,
        PH_RECHECK = 2'd3
    } phase_t;

    localparam logic [1:0] MODE_UPDATE = 2'd0;
    localparam logic [1:0] MODE_IRQ    = 2'd1;
    localparam logic [1:0] MODE_TIMER  = 2'd2;

    localparam logic [1:0] REG_TRIGGER_SOURCES  = 2'd0;
    localparam logic [1:0] REG_ASYNC_DELAY_MASK = 2'd1;
    localparam logic [1:0] REG_TIMER_MAP        = 2'd2;
    localparam logic [1:0] REG_INACTIVE_LEVELS  = 2'd3;

    localparam logic [1:0] SRC_NONE = 2'd3;

    typedef struct packed {
        logic [1:0] source_number;
        logic       sample_level;
        logic [2:0] device_index;
        logic [1:0] mode;
    } item_t;

    typedef struct packed {
        logic [1:0] timer_number;
        logic       timer_start;
        logic       level_changed;
        logic [1:0] device_phase;
        logic [7:0] stable_levels;
    } result_t;

    function automatic logic [1:0] pair_of(input logic [15:0] r, input logic [3:0] d);
        logic [1:0] v;
        v = 2'd0;
        if (!d[3]) begin
            v = r[{d[2:0], 1'b0} +: 2];
        end
        return v;
    endfunction

    function automatic logic bit_of(input logic [7:0] r, input logic [3:0] d);
        logic v;
        v = 1'b0;
        if (!d[3]) begin
            v = r[d[2:0]];
        end
        return v;
    endfunction

endpackage

// ===== hw/rtl/multi_channel_debounce_fsm_top.sv =====
// Multi-channel debounce state machine with its phase table in a synchronous memory.
// A transaction that needs no walk goes from acceptance through S_STEP and S_OUT to m_tvalid.
// A broadcast walks every device entry in S_WALK, then goes through S_FETCH, S_STEP and S_OUT to m_tvalid.
// One transaction is worked at a time; the next is accepted while a result waits.
// The phase memory reads through one registered port; per-entry valid bits make unwritten
// entries read as idle. Synchronous active-low reset idles all devices at once.
module multi_channel_debounce_fsm_top #(
    parameter int DEVICES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] mode, [4:2] device_index, [5] sample_level, [7:6] source_number
    input  logic [7:0]  s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] stable_levels, [9:8] device_phase, [10] level_changed, [11] timer_start,
    // [13:12] timer_number, [15:14] zero
    output logic [15:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = (DEVICES > 1) ? $clog2(DEVICES) : 1;
    localparam logic [IW-1:0] LAST_DEV = IW'(DEVICES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_FETCH,
        S_STEP,
        S_OUT
    } state_t;

    state_t              state_reg;
    mcdb_pkg::item_t     item_reg;
    logic [IW-1:0]       cnt_reg;
    logic [DEVICES-1:0]  valid_reg;
    logic [DEVICES-1:0]  stable_reg;
    logic [15:0]         trig_reg;
    logic [7:0]          adm_reg;
    logic [15:0]         tmap_reg;
    logic [7:0]          inact_reg;
    mcdb_pkg::result_t   res_reg;
    logic                m_tvalid_reg;
    logic [15:0]         m_tdata_reg;

    mcdb_pkg::phase_t    phase_mem [DEVICES];
    mcdb_pkg::phase_t    rd_data_reg;
    logic                rd_valid_reg;

    mcdb_pkg::item_t     in_item;
    logic                accept;
    logic                cfg_wr;
    logic                bcast;
    logic [4:0]          dev_ext;
    logic                dev_in_range;
    logic [IW-1:0]       dev_idx;
    logic [IW-1:0]       rd_addr;
    logic [IW-1:0]       wr_addr;
    logic                wr_en;
    mcdb_pkg::phase_t    wr_data;
    mcdb_pkg::phase_t    cur_ph;
    mcdb_pkg::phase_t    walk_ph;
    mcdb_pkg::phase_t    step_ph;
    logic                step_changed;
    logic                step_start;
    logic [1:0]          step_tnum;
    logic [DEVICES-1:0]  stable_next;
    logic [DEVICES-1:0]  reload_levels;
    logic [7:0]          stable_out;
    logic [3:0]          walk_dev;
    logic [3:0]          step_dev;

    assign in_item  = mcdb_pkg::item_t'(s_tdata);
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign bcast = ((in_item.mode == mcdb_pkg::MODE_IRQ) || (in_item.mode == mcdb_pkg::MODE_TIMER))
                   && (in_item.source_number != mcdb_pkg::SRC_NONE);

    assign dev_ext      = {2'b00, item_reg.device_index};
    assign dev_in_range = (dev_ext < 5'(DEVICES));
    assign dev_idx      = dev_ext[IW-1:0];
    assign walk_dev     = 4'(cnt_reg);
    assign step_dev     = 4'(dev_idx);
    assign cur_ph       = rd_valid_reg ? rd_data_reg : mcdb_pkg::PH_IDLE;

    always_comb begin
        unique case (paddr[3:2])
            mcdb_pkg::REG_TRIGGER_SOURCES:  prdata = {16'd0, trig_reg};
            mcdb_pkg::REG_ASYNC_DELAY_MASK: prdata = {24'd0, adm_reg};
            mcdb_pkg::REG_TIMER_MAP:        prdata = {16'd0, tmap_reg};
            mcdb_pkg::REG_INACTIVE_LEVELS:  prdata = {24'd0, inact_reg};
            default:                        prdata = 32'd0;
        endcase
    end

    always_comb begin
        for (int d = 0; d < DEVICES; d++) begin
            reload_levels[d] = mcdb_pkg::bit_of(pwdata[7:0], 4'(d));
        end
    end

    always_comb begin
        walk_ph = cur_ph;
        if (item_reg.mode == mcdb_pkg::MODE_IRQ) begin
            if ((mcdb_pkg::pair_of(trig_reg, walk_dev) == item_reg.source_number + 2'd1)
                && (cur_ph == mcdb_pkg::PH_IDLE)) begin
                walk_ph = mcdb_pkg::PH_EVENT;
            end
        end else if (mcdb_pkg::pair_of(tmap_reg, walk_dev) == item_reg.source_number) begin
            walk_ph = mcdb_pkg::PH_RECHECK;
        end
    end

    always_comb begin
        step_ph      = cur_ph;
        step_changed = 1'b0;
        step_start   = 1'b0;
        step_tnum    = 2'd0;
        stable_next  = stable_reg;
        if ((item_reg.mode == mcdb_pkg::MODE_UPDATE) && dev_in_range) begin
            unique case (cur_ph)
                mcdb_pkg::PH_IDLE: begin
                    if ((mcdb_pkg::pair_of(trig_reg, step_dev) == 2'd0)
                        && (item_reg.sample_level != stable_reg[dev_idx])) begin
                        step_ph = mcdb_pkg::PH_EVENT;
                    end
                end
                mcdb_pkg::PH_EVENT: begin
                    if (mcdb_pkg::bit_of(adm_reg, step_dev)) begin
                        step_start = 1'b1;
                        step_tnum  = mcdb_pkg::pair_of(tmap_reg, step_dev);
                        step_ph    = mcdb_pkg::PH_WAIT;
                    end else begin
                        step_ph = mcdb_pkg::PH_RECHECK;
                    end
                end
                mcdb_pkg::PH_WAIT: begin
                    step_ph = mcdb_pkg::PH_WAIT;
                end
                mcdb_pkg::PH_RECHECK: begin
                    if (item_reg.sample_level != stable_reg[dev_idx]) begin
                        stable_next[dev_idx] = item_reg.sample_level;
                        step_changed         = 1'b1;
                    end else begin
                        step_ph = mcdb_pkg::PH_IDLE;
                    end
                end
                default: begin
                    step_ph = cur_ph;
                end
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            stable_out[i] = (i < DEVICES) ? stable_next[i % DEVICES] : 1'b0;
        end
    end

    always_comb begin
        rd_addr = dev_idx;
        wr_en   = 1'b0;
        wr_addr = cnt_reg;
        wr_data = walk_ph;
        unique case (state_reg)
            S_IDLE: begin
                rd_addr = bcast ? IW'(0) : IW'({2'b00, in_item.device_index});
            end
            S_WALK: begin
                rd_addr = cnt_reg + IW'(1);
                wr_en   = 1'b1;
            end
            S_STEP: begin
                wr_en   = (item_reg.mode == mcdb_pkg::MODE_UPDATE) && dev_in_range;
                wr_addr = dev_idx;
                wr_data = step_ph;
            end
            default: begin
                rd_addr = dev_idx;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            phase_mem[wr_addr] <= wr_data;
        end
        rd_data_reg  <= phase_mem[rd_addr];
        rd_valid_reg <= valid_reg[rd_addr] && !(wr_en && (wr_addr == rd_addr));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            valid_reg    <= '0;
            stable_reg   <= '0;
            trig_reg     <= '0;
            adm_reg      <= '0;
            tmap_reg     <= '0;
            inact_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && (state_reg != S_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        item_reg  <= in_item;
                        cnt_reg   <= '0;
                        state_reg <= bcast ? S_WALK : S_STEP;
                    end
                end
                S_WALK: begin
                    if (cnt_reg == LAST_DEV) begin
                        state_reg <= S_FETCH;
                    end else begin
                        cnt_reg <= cnt_reg + IW'(1);
                    end
                end
                S_FETCH: begin
                    state_reg <= S_STEP;
                end
                S_STEP: begin
                    stable_reg            <= stable_next;
                    res_reg.stable_levels <= stable_out;
                    res_reg.device_phase  <= dev_in_range ? step_ph : mcdb_pkg::PH_IDLE;
                    res_reg.level_changed <= step_changed;
                    res_reg.timer_start   <= step_start;
                    res_reg.timer_number  <= step_tnum;
                    state_reg             <= S_OUT;
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {2'b00, res_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    mcdb_pkg::REG_TRIGGER_SOURCES:  trig_reg <= pwdata[15:0];
                    mcdb_pkg::REG_ASYNC_DELAY_MASK: adm_reg  <= pwdata[7:0];
                    mcdb_pkg::REG_TIMER_MAP:        tmap_reg <= pwdata[15:0];
                    mcdb_pkg::REG_INACTIVE_LEVELS: begin
                        inact_reg  <= pwdata[7:0];
                        stable_reg <= reload_levels;
                        valid_reg  <= '0;
                    end
                    default: begin
                        trig_reg <= trig_reg;
                    end
                endcase
            end
        end
    end

    a_change_not_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[10] && m_tdata[11]))
        else $error("level change and timer start reported together");

    a_tnum_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[11]) |-> (m_tdata[13:12] == 2'd0))
        else $error("timer number set without a timer start");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("second transaction accepted while one is in work");

    a_walk_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK && cnt_reg != LAST_DEV) |-> (rd_addr != wr_addr))
        else $error("walk read and write hit the same entry");

    a_reload_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_wr && paddr[3:2] == mcdb_pkg::REG_INACTIVE_LEVELS) |=> (valid_reg == '0))
        else $error("inactive level write did not idle the phase table");

endmodule
